>>> rtl/srlm_pkg.sv
package srlm_pkg;

  // Width of one edge coordinate, signed Q15.4.
  localparam int COORD_W = 20;

  // Width of one join limit register.
  localparam int LIMIT_W = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_X_GAP = 1'b0;
  localparam cfg_idx_t REG_Y_GAP = 1'b1;

  localparam logic [LIMIT_W-1:0] X_GAP_RESET = 10'd16;
  localparam logic [LIMIT_W-1:0] Y_GAP_RESET = 10'd16;

  // Depth of the flush command queue between front and back.
  localparam int CMD_DEPTH = 2;

endpackage

>>> rtl/srlm_if.sv
// Character box channel.
interface srlm_box_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [srlm_pkg::COORD_W-1:0]   box_left;
  logic signed [srlm_pkg::COORD_W-1:0]   box_top;
  logic signed [srlm_pkg::COORD_W-1:0]   box_right;
  logic signed [srlm_pkg::COORD_W-1:0]   box_bottom;
  logic                                  selection_end;

  modport source (output valid, box_left, box_top, box_right, box_bottom, selection_end,
                  input ready);
  modport sink   (input valid, box_left, box_top, box_right, box_bottom, selection_end,
                  output ready);
endinterface

// Line box channel.
interface srlm_line_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [srlm_pkg::COORD_W-1:0]   line_left;
  logic signed [srlm_pkg::COORD_W-1:0]   line_top;
  logic signed [srlm_pkg::COORD_W-1:0]   line_right;
  logic signed [srlm_pkg::COORD_W-1:0]   line_bottom;
  logic                                  last_of_item;

  modport source (output valid, line_left, line_top, line_right, line_bottom, last_of_item,
                  input ready);
  modport sink   (input valid, line_left, line_top, line_right, line_bottom, last_of_item,
                  output ready);
endinterface

// Configuration write channel.
interface srlm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [srlm_pkg::CFG_IDX_W-1:0]        reg_index;
  logic [srlm_pkg::CFG_DATA_W-1:0]       wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/srlm_cmd_fifo.sv
module srlm_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update, pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/srlm_front.sv
module srlm_front #(
  parameter  int MAX_RUN = 256,
  localparam int SUM_W   = srlm_pkg::COORD_W + $clog2(MAX_RUN),
  localparam int CNT_W   = $clog2(MAX_RUN + 1),
  localparam int CMD_W   = 2 * srlm_pkg::COORD_W + 2 * SUM_W + CNT_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  srlm_box_if.sink         box,
  srlm_cfg_if.sink         cfg,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output logic [CMD_W-1:0] push_data_o
);

  localparam int CW = srlm_pkg::COORD_W;
  localparam int LW = srlm_pkg::LIMIT_W;

  typedef struct packed {
    logic signed [CW-1:0]    min_left;
    logic signed [CW-1:0]    max_right;
    logic signed [SUM_W-1:0] sum_top;
    logic signed [SUM_W-1:0] sum_bottom;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } cmd_t;

  logic [LW-1:0]           x_lim_q, y_lim_q;
  logic                    run_open_q, run_open_d;
  logic signed [CW-1:0]    min_left_q, min_left_d;
  logic signed [CW-1:0]    max_right_q, max_right_d;
  logic signed [SUM_W-1:0] sum_top_q, sum_top_d;
  logic signed [SUM_W-1:0] sum_bot_q, sum_bot_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [CW-1:0]    prev_right_q, prev_top_q;
  logic                    pend_q;
  cmd_t                    pend_cmd_q;

  logic                    accept;
  logic signed [CW:0]      dx, dy;
  logic [CW:0]             ax, ay;
  logic                    join_run, flush_old, flush_new;
  logic signed [SUM_W-1:0] top_ext, bot_ext;
  cmd_t                    cmd_old, cmd_new, push_cmd;

  assign cfg.ready = 1'b1;
  assign box.ready = !pend_q && push_ready_i;
  assign accept    = box.valid && box.ready;

  // Classify the box: join test against the previous box, then the new run state.
  always_comb begin
    dx = {prev_right_q[CW-1], prev_right_q} - {box.box_left[CW-1], box.box_left};
    dy = {prev_top_q[CW-1], prev_top_q} - {box.box_top[CW-1], box.box_top};
    ax = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    ay = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    join_run = run_open_q
               && (ax < {{(CW + 1 - LW){1'b0}}, x_lim_q})
               && (ay < {{(CW + 1 - LW){1'b0}}, y_lim_q});
    flush_old = run_open_q && !join_run;

    top_ext = {{(SUM_W - CW){box.box_top[CW-1]}}, box.box_top};
    bot_ext = {{(SUM_W - CW){box.box_bottom[CW-1]}}, box.box_bottom};

    if (join_run) begin
      min_left_d  = (box.box_left < min_left_q) ? box.box_left : min_left_q;
      max_right_d = (box.box_right > max_right_q) ? box.box_right : max_right_q;
      sum_top_d   = sum_top_q + top_ext;
      sum_bot_d   = sum_bot_q + bot_ext;
      count_d     = count_q + CNT_W'(1);
    end else begin
      min_left_d  = box.box_left;
      max_right_d = box.box_right;
      sum_top_d   = top_ext;
      sum_bot_d   = bot_ext;
      count_d     = CNT_W'(1);
    end
    flush_new  = (count_d >= CNT_W'(MAX_RUN)) || box.selection_end;
    run_open_d = !flush_new;

    cmd_old = '{min_left: min_left_q, max_right: max_right_q, sum_top: sum_top_q,
                sum_bottom: sum_bot_q, count: count_q, last: !flush_new};
    cmd_new = '{min_left: min_left_d, max_right: max_right_d, sum_top: sum_top_d,
                sum_bottom: sum_bot_d, count: count_d, last: 1'b1};
  end

  // Queue push: a held second command goes first, else the first flush of this box.
  always_comb begin
    if (pend_q) begin
      push_cmd = pend_cmd_q;
    end else if (flush_old) begin
      push_cmd = cmd_old;
    end else begin
      push_cmd = cmd_new;
    end
  end

  assign push_valid_o = pend_q || (accept && (flush_old || flush_new));
  assign push_data_o  = push_cmd;

  // Run state, limits and the held command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lim_q      <= srlm_pkg::X_GAP_RESET;
      y_lim_q      <= srlm_pkg::Y_GAP_RESET;
      run_open_q   <= 1'b0;
      min_left_q   <= '0;
      max_right_q  <= '0;
      sum_top_q    <= '0;
      sum_bot_q    <= '0;
      count_q      <= '0;
      prev_right_q <= '0;
      prev_top_q   <= '0;
      pend_q       <= 1'b0;
      pend_cmd_q   <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.reg_index)
          srlm_pkg::REG_X_GAP: x_lim_q <= cfg.wdata;
          srlm_pkg::REG_Y_GAP: y_lim_q <= cfg.wdata;
          default: ;
        endcase
      end
      if (pend_q && push_ready_i) begin
        pend_q <= 1'b0;
      end
      if (accept) begin
        run_open_q   <= run_open_d;
        min_left_q   <= min_left_d;
        max_right_q  <= max_right_d;
        sum_top_q    <= sum_top_d;
        sum_bot_q    <= sum_bot_d;
        count_q      <= count_d;
        prev_right_q <= box.box_right;
        prev_top_q   <= box.box_top;
        if (flush_old && flush_new) begin
          pend_q     <= 1'b1;
          pend_cmd_q <= cmd_new;
        end
      end
    end
  end

  // A held command blocks new boxes.
  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !box.ready)
    else $error("box accepted while a flush command is held");

  // A box that closes two runs leaves the second one held.
  a_two_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && flush_old && flush_new) |=> pend_q)
    else $error("second flush command lost");

  // An open run always holds at least one box and never reaches the run limit.
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (count_q != '0) && (count_q < CNT_W'(MAX_RUN)))
    else $error("open run has an impossible box count");

endmodule

>>> rtl/srlm_back.sv
module srlm_back #(
  parameter  int MAX_RUN = 256,
  localparam int SUM_W   = srlm_pkg::COORD_W + $clog2(MAX_RUN),
  localparam int CNT_W   = $clog2(MAX_RUN + 1),
  localparam int CMD_W   = 2 * srlm_pkg::COORD_W + 2 * SUM_W + CNT_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  logic [CMD_W-1:0] pop_data_i,
  srlm_line_if.source      line
);

  localparam int CW    = srlm_pkg::COORD_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef struct packed {
    logic signed [CW-1:0]    min_left;
    logic signed [CW-1:0]    max_right;
    logic signed [SUM_W-1:0] sum_top;
    logic signed [SUM_W-1:0] sum_bottom;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e               state_q;
  cmd_t                 cmd;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     div_q;
  logic [SUM_W-1:0]     top_mag_q, top_mag_d;
  logic [SUM_W-1:0]     bot_mag_q, bot_mag_d;
  logic [CNT_W-1:0]     top_rem_q, top_rem_d;
  logic [CNT_W-1:0]     bot_rem_q, bot_rem_d;
  logic                 top_neg_q, bot_neg_q;
  logic [CNT_W:0]       top_shift, bot_shift;
  logic                 top_qbit, bot_qbit;
  logic [SUM_W-1:0]     top_res, bot_res;
  logic signed [CW-1:0] left_q, right_q, top_q, bottom_q;
  logic                 last_q, valid_q;

  assign cmd         = cmd_t'(pop_data_i);
  assign pop_ready_o = (state_q == ST_IDLE);

  assign line.valid        = valid_q;
  assign line.line_left    = left_q;
  assign line.line_top     = top_q;
  assign line.line_right   = right_q;
  assign line.line_bottom  = bottom_q;
  assign line.last_of_item = last_q;

  // One restoring division step on both magnitudes; quotient bits shift into the low end.
  always_comb begin
    top_shift = {top_rem_q, top_mag_q[SUM_W-1]};
    bot_shift = {bot_rem_q, bot_mag_q[SUM_W-1]};
    top_qbit  = (top_shift >= {1'b0, div_q});
    bot_qbit  = (bot_shift >= {1'b0, div_q});
    top_rem_d = top_qbit ? CNT_W'(top_shift - {1'b0, div_q}) : CNT_W'(top_shift);
    bot_rem_d = bot_qbit ? CNT_W'(bot_shift - {1'b0, div_q}) : CNT_W'(bot_shift);
    top_mag_d = {top_mag_q[SUM_W-2:0], top_qbit};
    bot_mag_d = {bot_mag_q[SUM_W-2:0], bot_qbit};
    top_res   = top_neg_q ? (~top_mag_d + SUM_W'(1)) : top_mag_d;
    bot_res   = bot_neg_q ? (~bot_mag_d + SUM_W'(1)) : bot_mag_d;
  end

  // Sequencer: load a command, divide both sums by the box count, present the line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      div_q     <= '0;
      top_mag_q <= '0;
      bot_mag_q <= '0;
      top_rem_q <= '0;
      bot_rem_q <= '0;
      top_neg_q <= 1'b0;
      bot_neg_q <= 1'b0;
      left_q    <= '0;
      right_q   <= '0;
      top_q     <= '0;
      bottom_q  <= '0;
      last_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            top_neg_q <= cmd.sum_top[SUM_W-1];
            bot_neg_q <= cmd.sum_bottom[SUM_W-1];
            top_mag_q <= cmd.sum_top[SUM_W-1] ? SUM_W'(-cmd.sum_top) : SUM_W'(cmd.sum_top);
            bot_mag_q <= cmd.sum_bottom[SUM_W-1] ? SUM_W'(-cmd.sum_bottom)
                                                 : SUM_W'(cmd.sum_bottom);
            top_rem_q <= '0;
            bot_rem_q <= '0;
            div_q     <= cmd.count;
            step_q    <= STEP_W'(SUM_W - 1);
            left_q    <= cmd.min_left;
            right_q   <= cmd.max_right;
            last_q    <= cmd.last;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          top_mag_q <= top_mag_d;
          bot_mag_q <= bot_mag_d;
          top_rem_q <= top_rem_d;
          bot_rem_q <= bot_rem_d;
          step_q    <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            top_q    <= top_res[CW-1:0];
            bottom_q <= bot_res[CW-1:0];
            valid_q  <= 1'b1;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (line.ready) begin
            valid_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A run always holds at least one box, so the divisor is never zero.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("division by a zero box count");

  // A line is shown only after a finished division.
  a_valid_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> ($past(state_q) == ST_DIV) && (state_q == ST_OUT))
    else $error("line shown without a division");

endmodule

>>> rtl/selection_rect_line_merger_core.sv
// A box that closes a run pushes a flush command into the queue; the back end loads it,
// divides both sums by the box count in shared steps and presents the line. A box that
// closes two runs gives the second line one division later. Boxes that close no run are
// taken one per cycle while the queue has room and no flush command is held; the back end
// takes no new command until its line is taken, and the queue holds two pending lines.
// Reset: asynchronous, active low; no run open, join limits return to 16.
module selection_rect_line_merger_core #(
  parameter int MAX_RUN = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srlm_box_if.sink     box_i,
  srlm_line_if.source  line_o,
  srlm_cfg_if.sink     cfg_i
);

  localparam int SUM_W = srlm_pkg::COORD_W + $clog2(MAX_RUN);
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int CMD_W = 2 * srlm_pkg::COORD_W + 2 * SUM_W + CNT_W + 1;

  logic             push_valid, push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [CMD_W-1:0] pop_data;

  // Front end: join test, run accumulation, flush commands.
  srlm_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .box          (box_i),
    .cfg          (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Flush command queue.
  srlm_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (srlm_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: averaging divider and line output register.
  srlm_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .line        (line_o)
  );

endmodule
